FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the rectangle allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication violated");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: hw/rtl/grffa_pkg.sv
// Package with the field widths, codes and defaults of the rectangle allocator.
`timescale 1ns / 1ps
package grffa_pkg;

   localparam int OPCODE_W   = 2;
   localparam int OWNER_W    = 8;
   localparam int RECT_W     = 5;
   localparam int INDEX_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam int GRID_CELLS_DEF = 256;
   localparam int MAX_SIDE_DEF   = 16;
   localparam int ID_BITS_DEF    = 8;

   typedef logic [OPCODE_W-1:0]   opcode_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam opcode_type OP_CHECK     = 2'd0;
   localparam opcode_type OP_PLACE     = 2'd1;
   localparam opcode_type OP_FIRST_FIT = 2'd2;

   localparam csr_index_type CSR_GRID_WIDTH  = 1'd0;
   localparam csr_index_type CSR_GRID_HEIGHT = 1'd1;

   localparam csr_data_type GRID_WIDTH_RST  = 5'd16;
   localparam csr_data_type GRID_HEIGHT_RST = 5'd16;

endpackage

FILE: hw/rtl/grffa_req_if.sv
// Request channel interface of the rectangle allocator.
`timescale 1ns / 1ps
interface grffa_req_if;
   import grffa_pkg::*;

   logic                valid;
   logic                ready;
   opcode_type          opcode;
   logic [OWNER_W-1:0]  owner_id;
   logic [RECT_W-1:0]   rect_width;
   logic [RECT_W-1:0]   rect_height;
   logic [INDEX_W-1:0]  top_left_index;

   modport source (output valid, output opcode, output owner_id, output rect_width,
                   output rect_height, output top_left_index, input ready);
   modport sink (input valid, input opcode, input owner_id, input rect_width,
                 input rect_height, input top_left_index, output ready);

endinterface

FILE: hw/rtl/grffa_rsp_if.sv
// Response channel interface of the rectangle allocator.
`timescale 1ns / 1ps
interface grffa_rsp_if;
   import grffa_pkg::*;

   logic               valid;
   logic               ready;
   logic               success;
   logic [INDEX_W-1:0] placed_index;

   modport source (output valid, output success, output placed_index, input ready);
   modport sink (input valid, input success, input placed_index, output ready);

endinterface

FILE: hw/rtl/grffa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module grffa_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 256)
   (input  logic                     clock,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/grid_rectangle_first_fit_allocator.sv
// Top level of the first-fit rectangle allocator over a grid of owner ids.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The owner grid lives in one RAM with a single read and a single write port, and each
// request that reaches the grid walks it one cell per cycle. After reset the block
// clears every RAM cell and accepts no request meanwhile. A check runs a bit-serial
// index divider, a setup step and one RAM read per covered cell, stopping at the first
// occupied one; a place runs the divider and the setup step and then one write per cell;
// a request whose index lies outside the grid goes straight to the result. First-fit
// tries each candidate index in order, with a setup step and up to one read per covered
// cell, and then writes the rectangle at the first free one. One request is in work at
// a time; the result waits in an output register while the next request is taken.
module grid_rectangle_first_fit_allocator
   #(parameter int GRID_CELLS = grffa_pkg::GRID_CELLS_DEF,
     parameter int MAX_SIDE   = grffa_pkg::MAX_SIDE_DEF,
     parameter int ID_BITS    = grffa_pkg::ID_BITS_DEF)
   (input  logic                          clock,
    input  logic                          reset,
    grffa_req_if.sink                     req_chan,
    grffa_rsp_if.source                   rsp_chan,
    input  logic                          csr_we,
    input  logic [grffa_pkg::CSR_IDX_W-1:0]  csr_index,
    input  logic [grffa_pkg::CSR_DATA_W-1:0] csr_wdata);

   import grffa_pkg::*;

   localparam int AW   = $clog2(GRID_CELLS);
   localparam int SW   = $clog2(MAX_SIDE + 1);
   localparam int EW   = ((SW > RECT_W) ? SW : RECT_W) + 1;
   localparam int LWR  = $clog2(MAX_SIDE * MAX_SIDE + MAX_SIDE + GRID_CELLS + 1);
   localparam int LW   = (LWR > INDEX_W) ? LWR : INDEX_W;
   localparam int DCW  = $clog2(INDEX_W);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_PREP  = 3'd3;
   localparam logic [2:0] ST_FIT   = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]          state_ff, state_in;
   csr_data_type        grid_w_ff, grid_w_in;
   csr_data_type        grid_h_ff, grid_h_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   opcode_type          op_ff, op_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [RECT_W-1:0]   rw_ff, rw_in;
   logic [RECT_W-1:0]   rh_ff, rh_in;
   logic [LW-1:0]       idx_ff, idx_in;
   logic [SW-1:0]       sx_ff, sx_in;
   logic [SW-1:0]       sy_ff, sy_in;
   logic [SW-1:0]       div_rem_ff, div_rem_in;
   logic [INDEX_W-1:0]  div_q_ff, div_q_in;
   logic [DCW-1:0]      div_cnt_ff, div_cnt_in;
   logic [SW-1:0]       x_ff, x_in;
   logic [SW-1:0]       y_ff, y_in;
   logic [SW-1:0]       x_end_ff, x_end_in;
   logic [SW-1:0]       y_end_ff, y_end_in;
   logic [LW-1:0]       base_ff, base_in;
   logic [LW-1:0]       addr_ff, addr_in;
   logic                pend_ff, pend_in;
   logic                last_ff, last_in;
   logic                res_ok_ff, res_ok_in;
   logic [INDEX_W-1:0]  res_pos_ff, res_pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [INDEX_W-1:0]  rsp_pos_ff, rsp_pos_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [ID_BITS-1:0]  ram_wdata;
   logic                ram_re;
   logic [ID_BITS-1:0]  ram_rdata;

   logic [SW-1:0]       w_c, h_c;
   logic [2*SW-1:0]     cells_prod;
   logic [LW-1:0]       cells_n;
   logic [LW-1:0]       req_idx_ext;
   logic                req_fire;
   logic [EW-1:0]       x_sum, y_sum;
   logic                rect_inside;
   logic                rect_empty;
   logic                last_cell;
   logic                row_more;
   logic [LW-1:0]       next_idx;
   logic                cand_last;
   logic [SW:0]         div_shift;
   logic                div_ge;
   logic [SW-1:0]       div_rem_next;
   logic [INDEX_W-1:0]  div_q_next;
   logic                addr_in_mem;
   logic                fit_fail, fit_pass;

   function automatic logic [SW-1:0] clamp_side(input csr_data_type v);
      logic [SW-1:0] r;
      if (v == '0) begin
         r = SW'(1);
      end else if (int'(v) > MAX_SIDE) begin
         r = SW'(MAX_SIDE);
      end else begin
         r = SW'(v);
      end
      return r;
   endfunction

   assign w_c         = clamp_side(grid_w_ff);
   assign h_c         = clamp_side(grid_h_ff);
   assign cells_prod  = {{SW{1'b0}}, w_c} * {{SW{1'b0}}, h_c};
   assign cells_n     = LW'(cells_prod);
   assign req_idx_ext = LW'(req_chan.top_left_index);

   assign req_chan.ready = (state_ff == ST_IDLE) && !reset;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.success      = rsp_ok_ff;
   assign rsp_chan.placed_index = rsp_pos_ff;

   assign x_sum       = EW'(sx_ff) + EW'(rw_ff);
   assign y_sum       = EW'(sy_ff) + EW'(rh_ff);
   assign rect_inside = (x_sum <= EW'(w_c)) && (y_sum <= EW'(h_c));
   assign rect_empty  = (rw_ff == '0) || (rh_ff == '0);

   assign row_more    = (x_ff + SW'(1)) != x_end_ff;
   assign last_cell   = !row_more && ((y_ff + SW'(1)) == y_end_ff);
   assign addr_in_mem = addr_ff < LW'(GRID_CELLS);

   assign next_idx  = idx_ff + LW'(1);
   assign cand_last = next_idx >= cells_n;

   assign div_shift    = {div_rem_ff, div_q_ff[INDEX_W-1]};
   assign div_ge       = div_shift >= {1'b0, w_c};
   assign div_rem_next = div_ge ? SW'(div_shift - {1'b0, w_c}) : SW'(div_shift);
   assign div_q_next   = {div_q_ff[INDEX_W-2:0], div_ge};

   always_comb begin
      state_in     = state_ff;
      grid_w_in    = grid_w_ff;
      grid_h_in    = grid_h_ff;
      clr_addr_in  = clr_addr_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      rw_in        = rw_ff;
      rh_in        = rh_ff;
      idx_in       = idx_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      div_rem_in   = div_rem_ff;
      div_q_in     = div_q_ff;
      div_cnt_in   = div_cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x_end_in     = x_end_ff;
      y_end_in     = y_end_ff;
      base_in      = base_ff;
      addr_in      = addr_ff;
      pend_in      = 1'b0;
      last_in      = last_ff;
      res_ok_in    = res_ok_ff;
      res_pos_in   = res_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_pos_in   = rsp_pos_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff[AW-1:0];
      ram_wdata    = id_ff;
      ram_re       = 1'b0;
      fit_fail     = 1'b0;
      fit_pass     = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_w_in = csr_wdata;
            CSR_GRID_HEIGHT: grid_h_in = csr_wdata;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(GRID_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in  = req_chan.opcode;
               id_in  = ID_BITS'(req_chan.owner_id);
               rw_in  = req_chan.rect_width;
               rh_in  = req_chan.rect_height;
               idx_in = req_idx_ext;
               priority if (req_chan.opcode == OP_CHECK || req_chan.opcode == OP_PLACE) begin
                  if (req_idx_ext >= cells_n) begin
                     res_ok_in  = 1'b0;
                     res_pos_in = req_chan.top_left_index;
                     state_in   = ST_DONE;
                  end else begin
                     div_rem_in = '0;
                     div_q_in   = req_chan.top_left_index;
                     div_cnt_in = '0;
                     state_in   = ST_DIV;
                  end
               end else if (req_chan.opcode == OP_FIRST_FIT) begin
                  idx_in   = '0;
                  sx_in    = '0;
                  sy_in    = '0;
                  state_in = ST_PREP;
               end else begin
                  res_ok_in  = 1'b0;
                  res_pos_in = '0;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            div_rem_in = div_rem_next;
            div_q_in   = div_q_next;
            div_cnt_in = div_cnt_ff + DCW'(1);
            if (div_cnt_ff == DCW'(INDEX_W - 1)) begin
               sx_in    = div_rem_next;
               sy_in    = SW'(div_q_next);
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            x_in     = sx_ff;
            y_in     = sy_ff;
            base_in  = idx_ff - LW'(sx_ff);
            addr_in  = idx_ff;
            last_in  = 1'b0;
            x_end_in = (x_sum > EW'(w_c)) ? w_c : SW'(x_sum);
            y_end_in = (y_sum > EW'(h_c)) ? h_c : SW'(y_sum);
            if (op_ff == OP_PLACE) begin
               if (rect_empty) begin
                  res_ok_in  = 1'b1;
                  res_pos_in = INDEX_W'(idx_ff);
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_WRITE;
               end
            end else if (rect_empty) begin
               fit_pass = 1'b1;
            end else if (!rect_inside) begin
               fit_fail = 1'b1;
            end else begin
               state_in = ST_FIT;
            end
         end
         ST_FIT: begin
            if (pend_ff && ram_rdata != '0) begin
               fit_fail = 1'b1;
            end else if (last_ff) begin
               fit_pass = 1'b1;
            end else if (!addr_in_mem) begin
               fit_fail = 1'b1;
            end else begin
               ram_re  = 1'b1;
               pend_in = 1'b1;
               last_in = last_cell;
               if (row_more) begin
                  x_in    = x_ff + SW'(1);
                  addr_in = addr_ff + LW'(1);
               end else begin
                  x_in    = sx_ff;
                  y_in    = y_ff + SW'(1);
                  base_in = base_ff + LW'(w_c);
                  addr_in = base_ff + LW'(w_c) + LW'(sx_ff);
               end
            end
         end
         ST_WRITE: begin
            ram_we = addr_in_mem;
            if (row_more) begin
               x_in    = x_ff + SW'(1);
               addr_in = addr_ff + LW'(1);
            end else begin
               x_in    = sx_ff;
               y_in    = y_ff + SW'(1);
               base_in = base_ff + LW'(w_c);
               addr_in = base_ff + LW'(w_c) + LW'(sx_ff);
            end
            if (last_cell) begin
               res_ok_in  = 1'b1;
               res_pos_in = INDEX_W'(idx_ff);
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_pos_in   = res_pos_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fit_fail) begin
         if (op_ff == OP_FIRST_FIT) begin
            if (cand_last) begin
               res_ok_in  = 1'b0;
               res_pos_in = '0;
               state_in   = ST_DONE;
            end else begin
               idx_in = next_idx;
               if (sx_ff == w_c - SW'(1)) begin
                  sx_in = '0;
                  sy_in = sy_ff + SW'(1);
               end else begin
                  sx_in = sx_ff + SW'(1);
               end
               state_in = ST_PREP;
            end
         end else begin
            res_ok_in  = 1'b0;
            res_pos_in = INDEX_W'(idx_ff);
            state_in   = ST_DONE;
         end
      end

      if (fit_pass) begin
         if (op_ff == OP_FIRST_FIT && !rect_empty) begin
            x_in     = sx_ff;
            y_in     = sy_ff;
            base_in  = idx_ff - LW'(sx_ff);
            addr_in  = idx_ff;
            last_in  = 1'b0;
            state_in = ST_WRITE;
         end else begin
            res_ok_in  = 1'b1;
            res_pos_in = INDEX_W'(idx_ff);
            state_in   = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         grid_w_ff    <= GRID_WIDTH_RST;
         grid_h_ff    <= GRID_HEIGHT_RST;
         clr_addr_ff  <= '0;
         div_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_w_ff    <= grid_w_in;
         grid_h_ff    <= grid_h_in;
         clr_addr_ff  <= clr_addr_in;
         div_cnt_ff   <= div_cnt_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      id_ff      <= id_in;
      rw_ff      <= rw_in;
      rh_ff      <= rh_in;
      idx_ff     <= idx_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      div_rem_ff <= div_rem_in;
      div_q_ff   <= div_q_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      x_end_ff   <= x_end_in;
      y_end_ff   <= y_end_in;
      base_ff    <= base_in;
      addr_ff    <= addr_in;
      res_ok_ff  <= res_ok_in;
      res_pos_ff <= res_pos_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   grffa_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (GRID_CELLS)
   ) u_cell_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (addr_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   `ASSERT_IMPLIES(a_fit_never_writes, clock, reset, state_ff == ST_FIT, !ram_we)
   `ASSERT_NEXT(a_accept_starts_work, clock, reset, req_fire, state_ff != ST_IDLE)
   `ASSERT_IMPLIES(a_write_in_region, clock, reset, state_ff == ST_WRITE,
                   (x_ff < x_end_ff) && (y_ff < y_end_ff))
   `ASSERT_NEXT(a_done_loads_result, clock, reset,
                (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready),
                rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

FILE: verif/grid_rectangle_first_fit_allocator_tb.sv
// Self-checking testbench for the first-fit rectangle allocator, with a grid predictor.
`timescale 1ns / 1ps
module grid_rectangle_first_fit_allocator_tb;
   import grffa_pkg::*;

   localparam opcode_type OP_UNUSED = 2'd3;
   localparam int N_DIRECTED = 23;
   localparam int PHASES = 13;
   localparam int ITEMS_PER_PHASE = 109;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef struct packed {
      opcode_type          opcode;
      logic [OWNER_W-1:0]  owner_id;
      logic [RECT_W-1:0]   rect_width;
      logic [RECT_W-1:0]   rect_height;
      logic [INDEX_W-1:0]  top_left_index;
   } alloc_req_type;

   typedef struct packed {
      logic                success;
      logic [INDEX_W-1:0]  placed_index;
   } alloc_rsp_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [OWNER_W-1:0]  owner_id;
      logic [RECT_W-1:0]   rect_width;
      logic [RECT_W-1:0]   rect_height;
      logic [INDEX_W-1:0]  top_left_index;
      logic                typed;
      logic                exp_success;
      logic [INDEX_W-1:0]  exp_index;
   } directed_row_type;

   // Rows with typed set carry an expectation that is obvious from the grid contents.
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{OP_CHECK,     8'd1,   5'd1,  5'd1,  8'd0,   1'b1, 1'b1, 8'd0},
      '{OP_CHECK,     8'd1,   5'd16, 5'd16, 8'd0,   1'b1, 1'b1, 8'd0},
      '{OP_CHECK,     8'd1,   5'd17, 5'd1,  8'd0,   1'b1, 1'b0, 8'd0},
      '{OP_CHECK,     8'd1,   5'd0,  5'd0,  8'd255, 1'b1, 1'b1, 8'd255},
      '{OP_CHECK,     8'd255, 5'd31, 5'd31, 8'd255, 1'b1, 1'b0, 8'd255},
      '{OP_UNUSED,    8'd255, 5'd31, 5'd31, 8'd255, 1'b1, 1'b0, 8'd0},
      '{OP_PLACE,     8'd255, 5'd2,  5'd2,  8'd17,  1'b1, 1'b1, 8'd17},
      '{OP_CHECK,     8'd1,   5'd1,  5'd1,  8'd17,  1'b1, 1'b0, 8'd17},
      '{OP_CHECK,     8'd1,   5'd1,  5'd1,  8'd16,  1'b1, 1'b1, 8'd16},
      '{OP_FIRST_FIT, 8'h5A,  5'd16, 5'd16, 8'd0,   1'b1, 1'b0, 8'd0},
      '{OP_PLACE,     8'h81,  5'd31, 5'd31, 8'd240, 1'b1, 1'b1, 8'd240},
      '{OP_FIRST_FIT, 8'd1,   5'd1,  5'd1,  8'd77,  1'b1, 1'b1, 8'd0},
      '{OP_FIRST_FIT, 8'd2,   5'd0,  5'd0,  8'd200, 1'b1, 1'b1, 8'd0},
      '{OP_PLACE,     8'd3,   5'd0,  5'd5,  8'd255, 1'b1, 1'b1, 8'd255},
      '{OP_FIRST_FIT, 8'hAA,  5'd16, 5'd1,  8'd0,   1'b0, 1'b0, 8'd0},
      '{OP_PLACE,     8'd0,   5'd16, 5'd16, 8'd0,   1'b1, 1'b1, 8'd0},
      '{OP_FIRST_FIT, 8'h7F,  5'd15, 5'd15, 8'd0,   1'b0, 1'b0, 8'd0},
      '{OP_CHECK,     8'd1,   5'd1,  5'd1,  8'd15,  1'b0, 1'b0, 8'd0},
      '{OP_PLACE,     8'h10,  5'd16, 5'd16, 8'd255, 1'b1, 1'b1, 8'd255},
      '{OP_FIRST_FIT, 8'h20,  5'd2,  5'd2,  8'd0,   1'b0, 1'b0, 8'd0},
      '{OP_PLACE,     8'hFF,  5'd31, 5'd31, 8'd0,   1'b1, 1'b1, 8'd0},
      '{OP_CHECK,     8'd1,   5'd1,  5'd1,  8'd100, 1'b1, 1'b0, 8'd100},
      '{OP_PLACE,     8'd0,   5'd16, 5'd16, 8'd0,   1'b1, 1'b1, 8'd0}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   csr_data_type csr_wdata;

   grffa_req_if req_bus();
   grffa_rsp_if rsp_bus();

   grid_rectangle_first_fit_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [OWNER_W-1:0] model_cells [GRID_CELLS_DEF];
   csr_data_type model_width;
   csr_data_type model_height;
   alloc_rsp_type pending_outcomes [$];
   int mismatch_count = 0;
   bit idle_on = 1'b1;
   bit hold_rsp_req = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int used_side(input csr_data_type v);
      int s;
      s = int'(v);
      if (s < 1) return 1;
      if (s > MAX_SIDE_DEF) return MAX_SIDE_DEF;
      return s;
   endfunction

   function automatic bit rect_is_free(input int idx, input int rw, input int rh);
      int w;
      int h;
      int sx;
      int sy;
      int a;
      w = used_side(model_width);
      h = used_side(model_height);
      if (idx >= w * h) return 1'b0;
      sx = idx % w;
      sy = idx / w;
      for (int y = sy; y < sy + rh; y++) begin
         for (int x = sx; x < sx + rw; x++) begin
            if (x >= w || y >= h) return 1'b0;
            a = x + y * w;
            if (a >= GRID_CELLS_DEF) return 1'b0;
            if (model_cells[a] != '0) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void paint_rect(input int idx, input int rw, input int rh,
                                      input logic [OWNER_W-1:0] id);
      int w;
      int h;
      int sx;
      int sy;
      int a;
      w = used_side(model_width);
      h = used_side(model_height);
      sx = idx % w;
      sy = idx / w;
      for (int y = sy; y < sy + rh; y++) begin
         for (int x = sx; x < sx + rw; x++) begin
            a = x + y * w;
            if (x < w && y < h && a < GRID_CELLS_DEF) model_cells[a] = id;
         end
      end
   endfunction

   function automatic alloc_rsp_type predict_allocation(input alloc_req_type r);
      alloc_rsp_type res;
      int cells;
      int idx;
      int rw;
      int rh;
      res = '0;
      cells = used_side(model_width) * used_side(model_height);
      idx = int'(r.top_left_index);
      rw = int'(r.rect_width);
      rh = int'(r.rect_height);
      case (r.opcode)
         OP_CHECK: begin
            res.success = rect_is_free(idx, rw, rh);
            res.placed_index = r.top_left_index;
         end
         OP_PLACE: begin
            res.placed_index = r.top_left_index;
            if (idx < cells) begin
               paint_rect(idx, rw, rh, r.owner_id);
               res.success = 1'b1;
            end
         end
         OP_FIRST_FIT: begin
            for (int i = 0; i < cells; i++) begin
               if (rect_is_free(i, rw, rh)) begin
                  paint_rect(i, rw, rh, r.owner_id);
                  res.success = 1'b1;
                  res.placed_index = INDEX_W'(i);
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic logic [RECT_W-1:0] random_side();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 88) return RECT_W'($urandom_range(0, 4));
      if (roll < 97) return RECT_W'($urandom_range(5, 16));
      return RECT_W'($urandom_range(17, 31));
   endfunction

   function automatic alloc_req_type random_request();
      alloc_req_type r;
      int cells;
      int pick;
      cells = used_side(model_width) * used_side(model_height);
      pick = int'($urandom_range(0, 99));
      r.owner_id = OWNER_W'($urandom_range(1, 255));
      r.rect_width = random_side();
      r.rect_height = random_side();
      if ($urandom_range(0, 9) < 7) r.top_left_index = INDEX_W'($urandom_range(0, cells - 1));
      else r.top_left_index = INDEX_W'($urandom_range(0, 255));
      if (pick < 40) r.opcode = OP_FIRST_FIT;
      else if (pick < 65) r.opcode = OP_CHECK;
      else if (pick < 90) r.opcode = OP_PLACE;
      else if (pick < 93) r.opcode = OP_UNUSED;
      else begin
         // Releasing a region by writing the empty id over it.
         r.opcode = OP_PLACE;
         r.owner_id = '0;
         if (pick >= 97) begin
            r.rect_width = RECT_W'(MAX_SIDE_DEF);
            r.rect_height = RECT_W'(MAX_SIDE_DEF);
            r.top_left_index = '0;
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      if (idle_on && $urandom_range(0, 3) == 0) return int'($urandom_range(1, 14));
      return 0;
   endfunction

   task automatic offer_request(input alloc_req_type r, input int gap, input bit typed,
                                input alloc_rsp_type typed_rsp);
      alloc_rsp_type predicted;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= r.opcode;
      req_bus.owner_id <= r.owner_id;
      req_bus.rect_width <= r.rect_width;
      req_bus.rect_height <= r.rect_height;
      req_bus.top_left_index <= r.top_left_index;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predicted = predict_allocation(r);
      pending_outcomes.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic drain_requests();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_grid(input csr_data_type gw, input csr_data_type gh);
      csr_we <= 1'b1;
      csr_index <= CSR_GRID_WIDTH;
      csr_wdata <= gw;
      @(posedge clock);
      csr_index <= CSR_GRID_HEIGHT;
      csr_wdata <= gh;
      @(posedge clock);
      csr_we <= 1'b0;
      model_width = gw;
      model_height = gh;
   endtask

   initial begin : request_side
      alloc_req_type stim;
      alloc_rsp_type typed_rsp;
      csr_data_type gw;
      csr_data_type gh;
      for (int i = 0; i < GRID_CELLS_DEF; i++) model_cells[i] = '0;
      model_width = GRID_WIDTH_RST;
      model_height = GRID_HEIGHT_RST;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_GRID_WIDTH;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.opcode <= OP_CHECK;
      req_bus.owner_id <= '0;
      req_bus.rect_width <= '0;
      req_bus.rect_height <= '0;
      req_bus.top_left_index <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         stim.opcode = DIRECTED_ROWS[i].opcode;
         stim.owner_id = DIRECTED_ROWS[i].owner_id;
         stim.rect_width = DIRECTED_ROWS[i].rect_width;
         stim.rect_height = DIRECTED_ROWS[i].rect_height;
         stim.top_left_index = DIRECTED_ROWS[i].top_left_index;
         typed_rsp.success = DIRECTED_ROWS[i].exp_success;
         typed_rsp.placed_index = DIRECTED_ROWS[i].exp_index;
         offer_request(stim, pick_gap(), DIRECTED_ROWS[i].typed, typed_rsp);
      end

      typed_rsp = '0;
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_requests();
         case (phase)
            0: begin gw = 5'd16; gh = 5'd16; end
            1: begin gw = 5'd1;  gh = 5'd1;  end
            2: begin gw = 5'd0;  gh = 5'd31; end
            3: begin gw = 5'd31; gh = 5'd0;  end
            4: begin gw = 5'd31; gh = 5'd31; end
            default: begin
               gw = CSR_DATA_W'($urandom_range(1, 16));
               gh = CSR_DATA_W'($urandom_range(1, 16));
            end
         endcase
         program_grid(gw, gh);
         idle_on = (phase < PHASES - 2) && (phase % 4 != 3);
         stim = '{OP_PLACE, 8'd0, RECT_W'(MAX_SIDE_DEF), RECT_W'(MAX_SIDE_DEF), 8'd0};
         offer_request(stim, pick_gap(), 1'b0, typed_rsp);
         if (phase == 0) hold_rsp_req = 1'b1;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (phase == 5 && k == ITEMS_PER_PHASE / 2) drain_requests();
            offer_request(random_request(), pick_gap(), 1'b0, typed_rsp);
         end
      end

      drain_requests();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : response_side
      alloc_rsp_type want;
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: unexpected transaction, success=%0b index=%0d",
                        $time, rsp_bus.success, rsp_bus.placed_index);
               mismatch_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_bus.success !== want.success) begin
                  $display("%0t: success expected %0b, got %0b",
                           $time, want.success, rsp_bus.success);
                  mismatch_count++;
               end
               if (rsp_bus.placed_index !== want.placed_index) begin
                  $display("%0t: placed_index expected %0d, got %0d",
                           $time, want.placed_index, rsp_bus.placed_index);
                  mismatch_count++;
               end
            end
         end
         if (hold_rsp_req) begin
            stall_left = LONG_HOLD_CYCLES;
            hold_rsp_req = 1'b0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = int'($urandom_range(1, 14));
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      #1_000_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
